@@ src/wcos_pkg.sv @@
// ----------------------------------------------------------------------------
// wcos_pkg: shared types and constants for the windowed circular orbit stepper
// Holds register indexes, the CORDIC arctangent table and controller commands.
// ----------------------------------------------------------------------------
package wcos_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_START_TIME = 3'd0;
	localparam logic [2:0] REG_END_TIME   = 3'd1;
	localparam logic [2:0] REG_INIT_PHASE = 3'd2;
	localparam logic [2:0] REG_PHASE_STEP = 3'd3;
	localparam logic [2:0] REG_RADIUS     = 3'd4;

	// inverse CORDIC gain in Q2.30, converged value
	localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

	// arctangent of 2^-i in turns over 2^32
	function automatic logic [31:0] atan_turns(input logic [4:0] i);
		logic [31:0] v;
		begin
			unique case (i)
				5'd0:  v = 32'd536870912;
				5'd1:  v = 32'd316933406;
				5'd2:  v = 32'd167458907;
				5'd3:  v = 32'd85004756;
				5'd4:  v = 32'd42667331;
				5'd5:  v = 32'd21354465;
				5'd6:  v = 32'd10679838;
				5'd7:  v = 32'd5340245;
				5'd8:  v = 32'd2670163;
				5'd9:  v = 32'd1335087;
				5'd10: v = 32'd667544;
				5'd11: v = 32'd333772;
				5'd12: v = 32'd166886;
				5'd13: v = 32'd83443;
				5'd14: v = 32'd41722;
				5'd15: v = 32'd20861;
				5'd16: v = 32'd10430;
				5'd17: v = 32'd5215;
				5'd18: v = 32'd2608;
				5'd19: v = 32'd1304;
				5'd20: v = 32'd652;
				5'd21: v = 32'd326;
				5'd22: v = 32'd163;
				5'd23: v = 32'd81;
				5'd24: v = 32'd41;
				5'd25: v = 32'd20;
				5'd26: v = 32'd10;
				5'd27: v = 32'd5;
				5'd28: v = 32'd3;
				5'd29: v = 32'd1;
				5'd30: v = 32'd1;
				default: v = 32'd0;
			endcase
			return v;
		end
	endfunction

	// controller to datapath commands
	typedef struct packed {
		logic load_batch;   // latch tick count, compute clipped count
		logic mul_start;    // start k-1 times step product
		logic cordic_prev;  // start CORDIC on the current phase
		logic cordic_last;  // start CORDIC on the last visited angle
		logic rad_mul;      // scale CORDIC result by radius
		logic take_prev;    // store scaled point as previous
		logic finish;       // form deltas, update state, load output
		logic idle_result;  // closed window or no motion, load output
	} wcos_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic closed;       // window closed before this batch
		logic moving;       // clipped count positive
		logic primed;       // previous point held
		logic mul_done;
		logic cordic_done;
	} wcos_sts_t;

endpackage

@@ src/windowed_circular_orbit_step.sv @@
// ----------------------------------------------------------------------------
// windowed_circular_orbit_step: circular orbit motion per tick batch
// Top level: stream ports, configuration port, controller and datapath.
// ----------------------------------------------------------------------------
// One batch word in gives one result word out, and one batch is in flight at
// a time. When the first point must be computed, the result word takes two
// passes through the shared iterative CORDIC plus an 8-step shift-add for the
// phase product; once a point is held, it takes one CORDIC pass plus the
// shift-add; when the window is closed or the batch falls outside it, the
// result word is loaded directly. The input is ready again in the cycle after
// the result word is taken, so no new batch is accepted before the result of
// the last one has been taken.
module windowed_circular_orbit_step #(
	parameter int CORDIC_ITERATIONS = 16,
	parameter int FRACTION_BITS     = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [31:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] tick_count
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata    // [31:0] delta_x, [63:32] delta_y, [64] still_active
);
	wcos_pkg::wcos_cmd_t cmd;
	wcos_pkg::wcos_sts_t sts;

	wcos_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_fire(s_tvalid && s_tready), .out_fire(m_tvalid && m_tready),
		.sts(sts), .cmd(cmd), .in_ready(s_tready), .out_valid(m_tvalid)
	);

	wcos_datapath #(
		.CORDIC_ITERATIONS(CORDIC_ITERATIONS), .FRACTION_BITS(FRACTION_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata), .tick_count(s_tdata), .cmd(cmd), .sts(sts),
		.result_word(m_tdata)
	);
endmodule

@@ src/wcos_cordic.sv @@
// ----------------------------------------------------------------------------
// wcos_cordic: iterative rotation CORDIC
// One micro-rotation per cycle; returns cosine and sine in Q2.30 with the
// quadrant already folded back in.
// ----------------------------------------------------------------------------
module wcos_cordic #(
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [31:0]        angle,
	output logic               done,
	output logic signed [33:0] cos_q,
	output logic signed [33:0] sin_q
);
	localparam int CW = $clog2(CORDIC_ITERATIONS + 1);
	localparam logic signed [33:0] CORDIC_GAIN = wcos_pkg::CORDIC_GAIN_Q30;

	logic signed [33:0] x_q, y_q;
	logic signed [33:0] z_q;
	logic [1:0]         quad_q;
	logic [CW-1:0]      cnt_q;
	logic               busy_q;
	logic [31:0]        a_rot;
	logic [4:0]         sh;

	assign a_rot = angle + 32'h2000_0000;
	assign sh    = 5'(cnt_q);

	// run micro-rotations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(CORDIC_ITERATIONS - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= CORDIC_GAIN;
			y_q    <= '0;
			z_q    <= $signed({4'b0, a_rot[29:0]}) - 34'sh2000_0000;
			quad_q <= a_rot[31:30];
		end else if (busy_q) begin
			if (!z_q[33]) begin
				x_q <= x_q - (y_q >>> sh);
				y_q <= y_q + (x_q >>> sh);
				z_q <= z_q - $signed({2'b0, wcos_pkg::atan_turns(sh)});
			end else begin
				x_q <= x_q + (y_q >>> sh);
				y_q <= y_q - (x_q >>> sh);
				z_q <= z_q + $signed({2'b0, wcos_pkg::atan_turns(sh)});
			end
		end
	end

	// fold quadrant
	always_comb begin
		case (quad_q)
			2'd0: begin cos_q = x_q;  sin_q = y_q;  end
			2'd1: begin cos_q = -y_q; sin_q = x_q;  end
			2'd2: begin cos_q = -x_q; sin_q = -y_q; end
			default: begin cos_q = y_q; sin_q = -x_q; end
		endcase
	end
endmodule

@@ src/wcos_datapath.sv @@
// ----------------------------------------------------------------------------
// wcos_datapath: window clipping, phase accumulation and point arithmetic
// Holds elapsed ticks, phase, last point and the output register.
// ----------------------------------------------------------------------------
module wcos_datapath #(
	parameter int CORDIC_ITERATIONS = 16,
	parameter int FRACTION_BITS     = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_addr,
	input  logic [31:0]         cfg_wdata,
	input  logic [7:0]          tick_count,
	input  wcos_pkg::wcos_cmd_t cmd,
	output wcos_pkg::wcos_sts_t sts,
	output logic [71:0]         result_word
);
	localparam int SH = 30 - FRACTION_BITS;

	logic [23:0] start_q, end_q;
	logic [31:0] step_q;
	logic signed [31:0] radius_q;
	logic [31:0] elapsed_q, phase_q;
	logic signed [31:0] last_x_q, last_y_q, prev_x_q, prev_y_q;
	logic primed_q;
	logic [7:0] n_q, k_q;
	logic closed_q;

	// clip arithmetic
	logic [32:0] t_plus_n;
	logic signed [33:0] k_full;
	logic        closed_now;
	assign t_plus_n   = {1'b0, elapsed_q} + 33'(tick_count);
	assign closed_now = (end_q != '0) && (elapsed_q >= 32'(end_q));
	always_comb begin
		k_full = 34'(tick_count);
		if (32'(start_q) > elapsed_q)
			k_full = k_full - $signed({2'b0, 32'(start_q) - elapsed_q});
		if (end_q != '0 && t_plus_n > 33'(end_q))
			k_full = k_full - $signed({1'b0, t_plus_n - 33'(end_q)});
	end

	logic [32:0] t_sum;
	assign t_sum = {1'b0, elapsed_q} + 33'(n_q);

	logic [31:0] prod_km1, prod_k, acc_q, mstep_q;
	logic [7:0]  mk_q;
	logic [3:0]  mcnt_q;
	logic        mbusy_q, mdone_q;

	// configuration and batch state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0; end_q <= '0; step_q <= '0;
			radius_q <= '0; elapsed_q <= '0; phase_q <= '0; primed_q <= 1'b0;
			closed_q <= 1'b0; k_q <= '0; n_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					wcos_pkg::REG_START_TIME: start_q <= cfg_wdata[23:0];
					wcos_pkg::REG_END_TIME:   end_q   <= cfg_wdata[23:0];
					wcos_pkg::REG_INIT_PHASE: begin
						if (!primed_q) phase_q <= cfg_wdata;
					end
					wcos_pkg::REG_PHASE_STEP: step_q   <= cfg_wdata;
					wcos_pkg::REG_RADIUS:     radius_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.load_batch) begin
				n_q      <= tick_count;
				closed_q <= closed_now;
				k_q      <= (k_full > 0) ? k_full[7:0] : 8'd0;
			end
			if (cmd.finish) begin
				primed_q <= 1'b1;
				phase_q  <= phase_q + prod_k;
			end
			if ((cmd.finish || cmd.idle_result) && !closed_q)
				elapsed_q <= t_sum[32] ? 32'hFFFF_FFFF : t_sum[31:0];
		end
	end

	// k-1 and k times step, by shift-add
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0; mdone_q <= 1'b0; mcnt_q <= '0;
		end else begin
			mdone_q <= 1'b0;
			if (cmd.mul_start) begin
				mbusy_q <= 1'b1; mcnt_q <= '0;
			end else if (mbusy_q) begin
				mcnt_q <= mcnt_q + 1'b1;
				if (mcnt_q == 4'd7) begin
					mbusy_q <= 1'b0; mdone_q <= 1'b1;
				end
			end
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			acc_q <= '0; mk_q <= k_q - 8'd1; mstep_q <= step_q;
		end else if (mbusy_q) begin
			if (mk_q[0]) acc_q <= acc_q + mstep_q;
			mk_q    <= mk_q >> 1;
			mstep_q <= mstep_q << 1;
		end
	end
	assign prod_km1 = acc_q;
	assign prod_k   = acc_q + step_q;

	// CORDIC
	logic        cd_start, cd_done;
	logic [31:0] cd_angle;
	logic signed [33:0] cd_cos, cd_sin;
	assign cd_start = cmd.cordic_prev || cmd.cordic_last;
	assign cd_angle = cmd.cordic_last ? (phase_q + prod_km1) : phase_q;
	wcos_cordic #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cd_start), .angle(cd_angle),
		.done(cd_done), .cos_q(cd_cos), .sin_q(cd_sin)
	);

	// round unit vector, then scale by radius (registered)
	logic signed [33:0] uc, us;
	assign uc = (cd_cos + (34'sd1 <<< (SH - 1))) >>> SH;
	assign us = (cd_sin + (34'sd1 <<< (SH - 1))) >>> SH;
	logic signed [65:0] mx_s1, my_s1;
	always_ff @(posedge clk) begin
		if (cmd.rad_mul) begin
			mx_s1 <= 66'(radius_q) * 66'(uc);
			my_s1 <= 66'(radius_q) * 66'(us);
		end
	end
	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (v < -66'sh8000_0000) return 32'sh8000_0000;
		return v[31:0];
	endfunction
	logic signed [31:0] px, py;
	assign px = sat32((mx_s1 + (66'sd1 <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS);
	assign py = sat32((my_s1 + (66'sd1 <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS);

	// previous and last points
	logic signed [31:0] dx, dy;
	assign dx = sat32(66'(px) - 66'(prev_x_q));
	assign dy = sat32(66'(py) - 66'(prev_y_q));
	always_ff @(posedge clk) begin
		if (cmd.take_prev) begin
			prev_x_q <= px; prev_y_q <= py;
		end else if (cmd.load_batch) begin
			prev_x_q <= last_x_q; prev_y_q <= last_y_q;
		end
		if (cmd.finish) begin
			last_x_q <= px; last_y_q <= py;
		end
	end

	// output word
	logic act_after;
	assign act_after = !((end_q != '0) &&
		((t_sum[32] ? 32'hFFFF_FFFF : t_sum[31:0]) >= 32'(end_q)));
	always_ff @(posedge clk) begin
		if (cmd.finish)
			result_word <= {7'b0, act_after, dy, dx};
		else if (cmd.idle_result)
			result_word <= {7'b0, closed_q ? 1'b0 : act_after, 32'd0, 32'd0};
	end

	assign sts.closed      = closed_q;
	assign sts.moving      = (k_q != 8'd0);
	assign sts.primed      = primed_q;
	assign sts.mul_done    = mdone_q;
	assign sts.cordic_done = cd_done;
endmodule

@@ src/wcos_ctrl.sv @@
// ----------------------------------------------------------------------------
// wcos_ctrl: batch sequencer
// Steps each batch through clipping, multiply, CORDIC passes and output.
// ----------------------------------------------------------------------------
module wcos_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	input  logic                out_fire,
	input  wcos_pkg::wcos_sts_t sts,
	output wcos_pkg::wcos_cmd_t cmd,
	output logic                in_ready,
	output logic                out_valid
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DEC   = 4'd1;
	localparam logic [3:0] S_MUL   = 4'd2;
	localparam logic [3:0] S_PREV  = 4'd3;
	localparam logic [3:0] S_PSCL  = 4'd4;
	localparam logic [3:0] S_PTAKE = 4'd5;
	localparam logic [3:0] S_LAST  = 4'd6;
	localparam logic [3:0] S_LSCL  = 4'd7;
	localparam logic [3:0] S_FIN   = 4'd8;
	localparam logic [3:0] S_OUT   = 4'd9;

	logic [3:0] state_q, state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_fire) begin
				cmd.load_batch = 1'b1; state_d = S_DEC;
			end
			S_DEC: begin
				if (sts.closed || !sts.moving) begin
					cmd.idle_result = 1'b1; state_d = S_OUT;
				end else begin
					cmd.mul_start = 1'b1; state_d = S_MUL;
				end
			end
			S_MUL: if (sts.mul_done) begin
				if (sts.primed) begin
					cmd.cordic_last = 1'b1; state_d = S_LAST;
				end else begin
					cmd.cordic_prev = 1'b1; state_d = S_PREV;
				end
			end
			S_PREV: if (sts.cordic_done) begin
				cmd.rad_mul = 1'b1; state_d = S_PSCL;
			end
			S_PSCL: begin cmd.take_prev = 1'b1; state_d = S_PTAKE; end
			S_PTAKE: begin cmd.cordic_last = 1'b1; state_d = S_LAST; end
			S_LAST: if (sts.cordic_done) begin
				cmd.rad_mul = 1'b1; state_d = S_LSCL;
			end
			S_LSCL: begin cmd.finish = 1'b1; state_d = S_FIN; end
			S_FIN:  state_d = S_OUT;
			S_OUT:  if (out_fire) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	a_one_cordic: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.cordic_prev && cmd.cordic_last)) else $error("two CORDIC starts");
	a_out_after: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire) |=> in_ready) else $error("no return to idle");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_batch |-> in_ready) else $error("load outside idle");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");
endmodule

@@ dv/tb_windowed_circular_orbit_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_windowed_circular_orbit_step: self-checking bench for the orbit stepper
// Drives tick batches over the input stream and configures the window, phase,
// step and radius between phases. A local CORDIC predictor computes the
// expected displacement words, which are compared field by field on output.
// ----------------------------------------------------------------------------
module tb_windowed_circular_orbit_step;

	typedef struct packed {
		logic        active;
		logic [31:0] dy;
		logic [31:0] dx;
	} motion_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_addr;
	logic [31:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] tick_count
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;   // [31:0] delta_x, [63:32] delta_y, [64] still_active

	// predictor copy of registers and state
	logic [23:0]        win_start, win_end;
	logic [31:0]        step_turns;
	logic signed [31:0] orbit_radius;
	logic [31:0]        ticks_seen, cur_phase;
	logic signed [31:0] prev_x, prev_y;
	logic               have_prev;

	motion_t motion_q[$];
	int      n_err, n_words, n_moving, n_closed;
	int      idle_pct;
	int      quiet_cycles;
	bit      done;

	localparam logic [31:0] ATAN_TBL [0:15] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
		32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
		32'd166886, 32'd83443, 32'd41722, 32'd20861};
	localparam int ITER = 16;
	localparam int FRAC = 16;
	localparam int QUIET_LIMIT = 20000;

	windowed_circular_orbit_step u_top (.*);

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fffffff;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// rotate to the angle, round sin/cos, scale by radius
	task automatic orbit_point(input logic [31:0] ang, output logic signed [31:0] px,
			output logic signed [31:0] py);
		logic [31:0]        a;
		logic [1:0]         quad;
		logic signed [63:0] x, y, z, dx, dy, c, s, uc, us;
		a = ang + 32'h20000000;
		quad = a[31:30];
		z = $signed({34'd0, a[29:0]}) - 64'sh20000000;
		x = 64'sd652032874;
		y = 0;
		for (int i = 0; i < ITER; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx; y = y + dy; z = z - $signed({32'd0, ATAN_TBL[i]});
			end else begin
				x = x + dx; y = y - dy; z = z + $signed({32'd0, ATAN_TBL[i]});
			end
		end
		case (quad)
			2'd0: begin c = x;  s = y;  end
			2'd1: begin c = -y; s = x;  end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
		uc = (c + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
		us = (s + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
		px = sat32((66'(orbit_radius) * 66'(uc) + (66'sd1 <<< (FRAC - 1))) >>> FRAC);
		py = sat32((66'(orbit_radius) * 66'(us) + (66'sd1 <<< (FRAC - 1))) >>> FRAC);
	endtask

	// advance the orbit by one batch and return the expected word
	task automatic orbit_batch(input logic [7:0] ticks, output motion_t r);
		longint             t, k, st, en;
		logic signed [31:0] px, py, cx, cy;
		logic [31:0]        last_ang;
		t = ticks_seen; st = win_start; en = win_end; k = ticks;
		r = '0;
		if (en != 0 && t >= en) return;
		if (st > t) k -= st - t;
		if (en != 0 && t + ticks > en) k -= t + ticks - en;
		if (k > 0) begin
			if (have_prev) begin
				px = prev_x; py = prev_y;
			end else begin
				orbit_point(cur_phase, px, py);
			end
			last_ang = cur_phase + 32'(k - 1) * step_turns;
			orbit_point(last_ang, cx, cy);
			r.dx = sat32(66'(cx) - 66'(px));
			r.dy = sat32(66'(cy) - 66'(py));
			prev_x = cx; prev_y = cy; have_prev = 1'b1;
			cur_phase = cur_phase + 32'(k) * step_turns;
		end
		t += ticks;
		if (t > 64'hffffffff) t = 64'hffffffff;
		ticks_seen = t[31:0];
		r.active = !(en != 0 && t >= en);
	endtask

	// hold off until nothing is in flight, then write one register
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		s_tvalid <= 1'b0;
		while (motion_q.size() != 0) @(posedge clk);
		cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			wcos_pkg::REG_START_TIME: win_start = val[23:0];
			wcos_pkg::REG_END_TIME:   win_end = val[23:0];
			wcos_pkg::REG_INIT_PHASE: begin
				if (!have_prev) cur_phase = val;
			end
			wcos_pkg::REG_PHASE_STEP: step_turns = val;
			wcos_pkg::REG_RADIUS:     orbit_radius = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// wait for every expected word, then let the block settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (motion_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic send_batch(input logic [7:0] ticks);
		motion_t r;
		while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1; s_tdata <= ticks;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		orbit_batch(ticks, r);
		motion_q.push_back(r);
	endtask

	task automatic set_orbit(input logic [23:0] st, input logic [23:0] en,
			input logic [31:0] ph, input logic [31:0] stp, input logic [31:0] rad);
		drain();
		write_reg(wcos_pkg::REG_START_TIME, {8'd0, st});
		write_reg(wcos_pkg::REG_END_TIME, {8'd0, en});
		write_reg(wcos_pkg::REG_INIT_PHASE, ph);
		write_reg(wcos_pkg::REG_PHASE_STEP, stp);
		write_reg(wcos_pkg::REG_RADIUS, rad);
	endtask

	// window edges, closed window, empty window, first motion
	task automatic test_window();
		set_orbit(24'd5, 24'd20, 32'h40000000, 32'h01000000, 32'sh00010000);
		send_batch(8'd0);
		send_batch(8'd3);
		send_batch(8'd4);
		send_batch(8'd1);
		send_batch(8'd255);
		send_batch(8'd1);
		send_batch(8'd7);
	endtask

	// extreme radius, zero step, full-range phase, radius change mid-motion
	task automatic test_extremes();
		set_orbit(24'd0, 24'd0, 32'hffffffff, 32'hffffffff, 32'sh7fffffff);
		send_batch(8'd1);
		send_batch(8'd255);
		send_batch(8'd128);
		write_reg(wcos_pkg::REG_RADIUS, 32'sh80000000);
		send_batch(8'd2);
		write_reg(wcos_pkg::REG_PHASE_STEP, 32'd0);
		send_batch(8'd200);
		// init_phase is ignored once primed
		write_reg(wcos_pkg::REG_INIT_PHASE, 32'h12345678);
		send_batch(8'd1);
		write_reg(wcos_pkg::REG_START_TIME, 32'h00ffffff);
		write_reg(wcos_pkg::REG_END_TIME, 32'h00ffffff);
		write_reg(wcos_pkg::REG_PHASE_STEP, 32'h80000000);
		send_batch(8'd9);
		drain();
		write_reg(wcos_pkg::REG_START_TIME, 32'd0);
		write_reg(wcos_pkg::REG_END_TIME, 32'd1);
		send_batch(8'd10);
	endtask

	// random batches over several random settings
	task automatic test_random();
		for (int ph = 0; ph < 10; ph++) begin
			idle_pct = (ph == 4) ? 0 : 36;
			drain();
			write_reg(wcos_pkg::REG_START_TIME, 32'($urandom_range(600, 0)));
			write_reg(wcos_pkg::REG_END_TIME, (ph % 3 == 0) ? 32'd0 :
				32'($urandom_range(20000, 0)) | (ph == 9 ? 32'hff0000 : 32'd0));
			write_reg(wcos_pkg::REG_INIT_PHASE, $urandom());
			write_reg(wcos_pkg::REG_PHASE_STEP, (ph == 7) ? 32'd0 : $urandom());
			write_reg(wcos_pkg::REG_RADIUS, (ph % 4 == 1) ? $urandom() : $urandom() >>> 8);
			for (int i = 0; i < 72; i++) begin
				if (i == 36 && ph == 2) drain();
				send_batch(8'($urandom_range(255, 0)));
			end
		end
	endtask

	// output side: random stall and compare
	always @(posedge clk) begin
		motion_t got, want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= !(idle_pct != 0 && $urandom_range(99, 0) < idle_pct);
			if (m_tvalid && m_tready) begin
				got = m_tdata[64:0];
				n_words++;
				if (motion_q.size() == 0) begin
					n_err++;
					if (n_err <= 10) $display("unexpected word %h", got);
				end else begin
					want = motion_q.pop_front();
					if (want.dx != 0 || want.dy != 0) n_moving++;
					if (!want.active) n_closed++;
					if (got.dx !== want.dx || got.dy !== want.dy
							|| got.active !== want.active) begin
						n_err++;
						if (n_err <= 10)
							$display("word %0d: dx exp %h got %h, dy exp %h got %h, act exp %b got %b",
								n_words, want.dx, got.dx, want.dy, got.dy, want.active,
								got.active);
					end
				end
			end
		end
	end

	// watchdog on handshake activity
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > QUIET_LIMIT && !done) begin
			$display("windowed_circular_orbit_step: mismatch");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
		s_tvalid = 1'b0; s_tdata = '0;
		n_err = 0; n_words = 0; n_moving = 0; n_closed = 0;
		idle_pct = 36; done = 1'b0;
		win_start = 0; win_end = 0; step_turns = 0; orbit_radius = 0;
		ticks_seen = 0; cur_phase = 0; prev_x = 0; prev_y = 0; have_prev = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_window();
		test_extremes();
		test_random();
		drain();
		done = 1'b1;
		if (motion_q.size() != 0) n_err++;
		$display("checked %0d words: %0d with motion, %0d with window closed",
			n_words, n_moving, n_closed);
		if (n_err == 0) begin
			$display("windowed_circular_orbit_step: match");
		end else begin
			$display("windowed_circular_orbit_step: mismatch");
		end
		$finish;
	end

endmodule
